/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/pec_pkg.sv */
package pec_pkg;

	localparam int MAX_ORDER_DEF     = 4;
	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int INDEX_BITS_DEF    = 32;

	// Widest values the parameters allow; job fields are sized for them.
	localparam int IDX_MAX_W  = 48;
	localparam int WP_MAX_W   = 11;
	localparam int SPAN_MAX_W = 10;
	// Doubled samples and level sums of up to 24-bit codes.
	localparam int CMP_W      = 26;
	localparam int LEV_W      = 16;
	localparam int CFG_W      = 32;
	localparam int OUT_DW     = 64;
	localparam int TIME_W     = 63;
	localparam int FRAC_W     = 16;

	typedef enum logic [2:0] {
		CFG_PAM_ORDER,
		CFG_LEVEL_ZERO,
		CFG_LEVEL_ONE,
		CFG_LEVEL_TWO,
		CFG_LEVEL_THREE,
		CFG_SAMPLE_PERIOD,
		CFG_HALF_UI,
		CFG_TRIGGER_PHASE
	} pec_cfg_idx_t;

	localparam logic [2:0]       RST_PAM_ORDER = 3'd3;
	localparam logic [LEV_W-1:0] RST_LEVEL_0   = 16'hC000;
	localparam logic [LEV_W-1:0] RST_LEVEL_1   = 16'h0000;
	localparam logic [LEV_W-1:0] RST_LEVEL_2   = 16'h4000;
	localparam logic [LEV_W-1:0] RST_LEVEL_3   = 16'h7FFF;
	localparam logic [CFG_W-1:0] RST_PERIOD    = 32'd100000;
	localparam logic [CFG_W-1:0] RST_HALF_UI   = 32'd400000;
	localparam logic [CFG_W-1:0] RST_TRIGGER   = 32'd0;

	typedef struct packed {
		logic [2:0]                  n;
		logic [3:0][LEV_W-1:0]       lev;
		logic [CFG_W-1:0]            period;
		logic [CFG_W-1:0]            half_ui;
		logic [CFG_W-1:0]            trigger;
	} pec_cfg_t;

	typedef struct packed {
		logic [IDX_MAX_W-1:0]        idx;
		logic [WP_MAX_W-1:0]         wp;
		logic [SPAN_MAX_W-1:0]       span;
		logic signed [CMP_W-1:0]     t2;
		logic                        merging;
		logic                        value;
	} pec_job_t;

	typedef struct packed {
		logic                        valid;
		logic [WP_MAX_W-1:0]         wp;
	} pec_hold_t;

endpackage

/* src/pec_ram.sv */
module pec_ram import pec_pkg::*; #(
	parameter int WIDTH = SAMPLE_BITS_DEF,
	parameter int DEPTH = 2 * HISTORY_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/pec_queue.sv */
module pec_queue import pec_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pec_job_t push_job,
	output logic     full,
	input  logic     pop,
	output logic     valid,
	output pec_job_t head
);

	pec_job_t   ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* src/pec_front.sv */
module pec_front import pec_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int INDEX_BITS    = INDEX_BITS_DEF,
	parameter int DW            = ((SAMPLE_BITS + 7) / 8) * 8,
	parameter int AW            = $clog2(2 * HISTORY_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pec_cfg_t               cfg,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DW-1:0]          s_tdata,
	input  logic                   s_tuser,
	input  pec_hold_t              hold,
	output logic                   ram_we,
	output logic [AW-1:0]          ram_waddr,
	output logic [SAMPLE_BITS-1:0] ram_wdata,
	output logic                   q_push,
	output pec_job_t               q_job,
	input  logic                   q_full
);

	localparam int IB = INDEX_BITS;
	localparam logic [IB:0] SPAN_CAP = (IB + 1)'(HISTORY_DEPTH - 3);

	typedef enum logic [2:0] {F_IDLE, F_M1, F_M2, F_M3, F_FIN} fstate_t;

	fstate_t                 state_q;
	logic [AW-1:0]           wp_q;
	logic [IB-1:0]           cnt_idx_q;
	logic signed [SAMPLE_BITS-1:0] h1_q, h2_q;
	logic [IB-1:0]           cidx0_q, cidx1_q;
	logic                    crise0_q, crise1_q;
	logic [1:0]              ccnt_q;
	logic                    tog_q;

	logic                    rise_q;
	logic [1:0]              symend_q;
	logic [IB-1:0]           jidx_q;
	logic [AW-1:0]           jwp_q;
	logic [1:0]              ocnt_q;
	logic [IB-1:0]           oidx0_q, oidx1_q;
	logic                    orise0_q, orise1_q;
	logic [IB:0]             span_q;
	logic signed [4:0]       ss_q;
	logic                    merg_q;
	logic [63:0]             prod_q;

	logic                    acc, stall, found, rise_c;
	logic [1:0]              symend_c;
	logic signed [CMP_W-1:0] p2, c2, thr;
	logic [AW-1:0]           wp_gap;
	logic [IB-1:0]           k, d0, d1;
	logic [1:0]              cnt_b;
	logic                    r0_b, r1_b;
	logic                    fits0, fits1, ok1, ok2;
	logic [1:0]              ssc;
	logic [IB:0]             spc, lim;
	logic [63:0]             mul_p;
	logic [31:0]             mul_a;

	assign wp_gap   = wp_q - AW'(hold.wp);
	assign stall    = hold.valid && (wp_gap >= AW'(HISTORY_DEPTH));
	assign s_tready = (state_q == F_IDLE) && !stall;
	assign acc      = s_tvalid && s_tready;

	assign ram_we    = acc;
	assign ram_waddr = wp_q;
	assign ram_wdata = s_tdata[SAMPLE_BITS-1:0];

	assign k     = s_tuser ? '0 : cnt_idx_q;
	assign cnt_b = s_tuser ? 2'd0 : ccnt_q;
	assign r0_b  = s_tuser ? 1'b0 : crise0_q;
	assign r1_b  = s_tuser ? 1'b0 : crise1_q;

	// Lowest level midpoint crossed by the previous sample pair.
	always_comb begin
		p2       = CMP_W'(h2_q) <<< 1;
		c2       = CMP_W'(h1_q) <<< 1;
		found    = 1'b0;
		rise_c   = 1'b0;
		symend_c = 2'd0;
		thr      = '0;
		for (int j = 0; j < 3; j++) begin
			thr = CMP_W'($signed(cfg.lev[j])) + CMP_W'($signed(cfg.lev[j + 1]));
			if (!found && (3'(j + 1) < cfg.n)) begin
				if (p2 <= thr && c2 > thr) begin
					found    = 1'b1;
					rise_c   = 1'b1;
					symend_c = 2'(j + 1);
				end else if (p2 >= thr && c2 < thr) begin
					found    = 1'b1;
					rise_c   = 1'b0;
					symend_c = 2'(j);
				end
			end
		end
	end

	assign d0    = jidx_q - oidx0_q;
	assign d1    = jidx_q - oidx1_q;
	assign fits0 = (64'(d0) >> 32) == 64'd0;
	assign fits1 = (64'(d1) >> 32) == 64'd0;
	assign ok1   = (cfg.n > 3'd2) && (ocnt_q > 2'd1) && fits0 && (orise0_q == rise_q)
			&& (prod_q < 64'(cfg.half_ui));
	assign ok2   = (ocnt_q > 2'd2) && fits1 && (orise1_q == rise_q)
			&& (prod_q < 64'(cfg.half_ui));

	assign mul_a = (state_q == F_M1) ? 32'(d0) : 32'(d1);
	assign mul_p = 64'(mul_a) * 64'(cfg.period);

	always_comb begin
		if (ss_q < 5'sd0) begin
			ssc = 2'd0;
		end else if (ss_q > $signed({2'b00, cfg.n}) - 5'sd1) begin
			ssc = 2'(cfg.n - 3'd1);
		end else begin
			ssc = 2'(ss_q);
		end
		lim = (IB + 1)'(jidx_q) - (IB + 1)'(1);
		spc = (span_q > SPAN_CAP) ? SPAN_CAP : span_q;
		if (spc > lim) begin
			spc = lim;
		end
	end

	assign q_push        = (state_q == F_FIN) && !q_full;
	assign q_job.idx     = IDX_MAX_W'(jidx_q);
	assign q_job.wp      = WP_MAX_W'(jwp_q);
	assign q_job.span    = SPAN_MAX_W'(spc);
	assign q_job.t2      = CMP_W'($signed(cfg.lev[ssc])) + CMP_W'($signed(cfg.lev[symend_q]));
	assign q_job.merging = merg_q;
	assign q_job.value   = merg_q ? ~tog_q : tog_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			rise_q   <= rise_c;
			symend_q <= symend_c;
			jidx_q   <= k - IB'(1);
			jwp_q    <= wp_q;
			ocnt_q   <= cnt_b;
			oidx0_q  <= cidx0_q;
			oidx1_q  <= cidx1_q;
			orise0_q <= r0_b;
			orise1_q <= r1_b;
			span_q   <= (IB + 1)'(1);
			ss_q     <= rise_c ? $signed(5'(symend_c)) - 5'sd1 : $signed(5'(symend_c)) + 5'sd1;
			merg_q   <= 1'b0;
		end
		if (state_q == F_M1 || (state_q == F_M2 && ok1)) begin
			prod_q <= mul_p;
		end
		if (state_q == F_M2 && ok1) begin
			merg_q <= 1'b1;
			span_q <= (IB + 1)'(d0) + (IB + 1)'(1);
			ss_q   <= rise_q ? $signed(5'(symend_q)) - 5'sd2 : $signed(5'(symend_q)) + 5'sd2;
		end
		if (state_q == F_M3 && ok2) begin
			merg_q <= 1'b1;
			span_q <= (IB + 1)'(d1) + (IB + 1)'(1);
			ss_q   <= rise_q ? $signed(5'(symend_q)) - 5'sd3 : $signed(5'(symend_q)) + 5'sd3;
		end
		if (acc) begin
			h2_q <= h1_q;
			h1_q <= $signed(s_tdata[SAMPLE_BITS-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			wp_q      <= '0;
			cnt_idx_q <= '0;
			ccnt_q    <= 2'd0;
			crise0_q  <= 1'b0;
			crise1_q  <= 1'b0;
			cidx0_q   <= '0;
			cidx1_q   <= '0;
			tog_q     <= 1'b1;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (acc) begin
						wp_q      <= wp_q + AW'(1);
						cnt_idx_q <= k + IB'(1);
						tog_q     <= s_tuser ? 1'b1 : tog_q;
						if (k >= IB'(2) && found) begin
							cidx1_q  <= cidx0_q;
							cidx0_q  <= k - IB'(1);
							crise1_q <= r0_b;
							crise0_q <= rise_c;
							ccnt_q   <= (cnt_b == 2'd3) ? 2'd3 : cnt_b + 2'd1;
							if (k != IB'(2)) begin
								state_q <= F_M1;
							end
						end else begin
							ccnt_q   <= cnt_b;
							crise0_q <= r0_b;
							crise1_q <= r1_b;
						end
					end
				end
				F_M1: begin
					state_q <= F_M2;
				end
				F_M2: begin
					state_q <= (ok1 && cfg.n > 3'd3) ? F_M3 : F_FIN;
				end
				F_M3: begin
					state_q <= F_FIN;
				end
				F_FIN: begin
					if (!q_full) begin
						if (!merg_q) begin
							tog_q <= ~tog_q;
						end
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/pec_back.sv */
module pec_back import pec_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int INDEX_BITS    = INDEX_BITS_DEF,
	parameter int AW            = $clog2(2 * HISTORY_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pec_cfg_t               cfg,
	input  logic                   q_valid,
	input  pec_job_t               q_job,
	output logic                   q_pop,
	output logic [AW-1:0]          ram_raddr,
	input  logic [SAMPLE_BITS-1:0] ram_rdata,
	output pec_hold_t              status,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DW-1:0]      m_tdata,
	output logic                   m_tuser
);

	localparam int IB    = INDEX_BITS;
	localparam int SPW   = $clog2(HISTORY_DEPTH);
	localparam int DIV_W = CMP_W + 2;

	typedef enum logic [3:0] {
		B_IDLE, B_RDA, B_RDB, B_CMP, B_DIV, B_MUL0, B_MUL1, B_MUL2, B_MUL3, B_FIN
	} bstate_t;

	bstate_t                 state_q;
	logic [IB-1:0]           idx_q;
	logic [AW-1:0]           wp_q;
	logic [SPW-1:0]          span_q;
	logic signed [CMP_W-1:0] t2_q, a2_q;
	logic                    merg_q, val_q;
	logic [DIV_W-1:0]        rem_q, den_q;
	logic [FRAC_W-1:0]       quo_q;
	logic [4:0]              step_q;
	logic [63:0]             acc_q, prod_q;
	logic                    ov_q, okind_q, oval_q;
	logic [TIME_W-1:0]       otime_q;

	logic signed [CMP_W-1:0] b2;
	logic                    hit;
	logic [DIV_W-1:0]        r2;
	logic [63:0]             base64, mul_p, total;
	logic [31:0]             mul_a;
	logic                    out_free;

	assign b2  = CMP_W'($signed(ram_rdata)) <<< 1;
	assign hit = (a2_q <= t2_q && b2 > t2_q) || (a2_q >= t2_q && b2 < t2_q);
	assign r2  = {rem_q[DIV_W-2:0], 1'b0};

	assign base64 = 64'(idx_q - IB'(span_q) - IB'(1));

	always_comb begin
		case (state_q)
			B_MUL0:  mul_a = base64[31:0];
			B_MUL1:  mul_a = base64[63:32];
			default: mul_a = 32'(quo_q);
		endcase
		case (state_q)
			B_RDA:   ram_raddr = wp_q - AW'(span_q) - AW'(2);
			B_RDB:   ram_raddr = wp_q - AW'(span_q) - AW'(1);
			default: ram_raddr = wp_q - AW'(span_q);
		endcase
	end

	assign mul_p    = 64'(mul_a) * 64'(cfg.period);
	assign total    = acc_q + 64'($signed(cfg.trigger));
	assign out_free = !ov_q || m_tready;
	assign q_pop    = (state_q == B_IDLE) && q_valid;

	assign status.valid = (state_q != B_IDLE);
	assign status.wp    = WP_MAX_W'(wp_q);

	assign m_tvalid = ov_q;
	assign m_tdata  = {oval_q, otime_q};
	assign m_tuser  = okind_q;

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				idx_q  <= IB'(q_job.idx);
				wp_q   <= AW'(q_job.wp);
				span_q <= SPW'(q_job.span);
				t2_q   <= q_job.t2;
				merg_q <= q_job.merging;
				val_q  <= q_job.value;
			end
			B_RDB: begin
				a2_q <= b2;
			end
			B_CMP: begin
				if (hit) begin
					rem_q  <= DIV_W'((a2_q <= t2_q) ? t2_q - a2_q : a2_q - t2_q);
					den_q  <= DIV_W'((b2 > a2_q) ? b2 - a2_q : a2_q - b2);
					step_q <= 5'd0;
				end else if (span_q == '0) begin
					acc_q <= 64'd0;
				end else begin
					span_q <= span_q - SPW'(1);
					a2_q   <= b2;
				end
			end
			B_DIV: begin
				step_q <= step_q + 5'd1;
				if (r2 >= den_q) begin
					rem_q <= r2 - den_q;
					quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
				end else begin
					rem_q <= r2;
					quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
				end
			end
			B_MUL0: begin
				prod_q <= mul_p;
			end
			B_MUL1: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			B_MUL2: begin
				acc_q  <= acc_q + (prod_q << 32);
				prod_q <= mul_p;
			end
			B_MUL3: begin
				acc_q <= acc_q + (prod_q >> FRAC_W);
			end
			default: begin
			end
		endcase
		if (state_q == B_FIN && out_free) begin
			otime_q <= total[TIME_W-1:0];
			okind_q <= merg_q;
			oval_q  <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (state_q == B_FIN && out_free) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_RDA;
					end
				end
				B_RDA: state_q <= B_RDB;
				B_RDB: state_q <= B_CMP;
				B_CMP: begin
					if (hit) begin
						state_q <= B_DIV;
					end else if (span_q == '0) begin
						state_q <= B_FIN;
					end
				end
				B_DIV: begin
					if (step_q == 5'(FRAC_W - 1)) begin
						state_q <= B_MUL0;
					end
				end
				B_MUL0: state_q <= B_MUL1;
				B_MUL1: state_q <= B_MUL2;
				B_MUL2: state_q <= B_MUL3;
				B_MUL3: state_q <= B_FIN;
				B_FIN: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

/* src/pam_edge_clock_recovery_top.sv */
// Multi-level edge detector with clock recovery.
// Input stream (s_*): one ADC sample per word; s_tuser flags the first sample
// of a new capture record, which restarts the sample count and edge state.
// Output stream (m_*): zero or one edge word per sample. m_tuser is 0 for a
// newly appended edge and 1 when the word replaces the time of the last edge.
// The configuration port writes one register per cycle; the user must write it
// only while the block is idle, which the block itself does not enforce. A
// sample without a crossing leaves the front end ready for the next one. A
// crossing holds the front end through F_M1, F_M2, F_M3 when a second merge
// step is tried, and F_FIN, with one multiply per merge step. The back end then
// takes the job and primes its single history read port (B_IDLE, B_RDA, B_RDB),
// tests one sample pair per B_CMP step (up to span + 1 pairs), runs the
// bit-serial divider for 16 quotient bits and the multiply and accumulate steps
// B_MUL0 to B_MUL3; if no pair straddles the target it skips both. A two-entry
// job queue lets the front end keep taking samples while the back end works;
// beside its crossing states, the front end stalls only once it is a whole
// history depth ahead of the oldest pending job or the queue is full. If the
// receiver holds m_tready low, the finished edge waits in the output register
// and the back end stops behind it. Reset returns the control and configuration
// registers to their defaults and empties the queue; the history memory needs
// no clearing, as only samples of the current record are ever read.
`include "assert_macros.svh"
module pam_edge_clock_recovery_top import pec_pkg::*; #(
	parameter int MAX_ORDER     = MAX_ORDER_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// sample (SAMPLE_BITS, signed), zero padding
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// record_start
	input  logic                                     s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// edge_time_fs [62:0], edge_value [63]
	output logic [OUT_DW-1:0]                        m_tdata,
	// edge_kind
	output logic                                     m_tuser,
	input  logic                                     cfg_we,
	input  logic [2:0]                               cfg_index,
	input  logic [CFG_W-1:0]                         cfg_data
);

	localparam int DW      = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int AW      = $clog2(2 * HISTORY_DEPTH);
	localparam int TOP_ORD = (MAX_ORDER < 4) ? MAX_ORDER : 4;

	logic [2:0]             order_q;
	logic [3:0][LEV_W-1:0]  lev_q;
	logic [CFG_W-1:0]       period_q, half_q, trig_q;
	pec_cfg_t               cfg;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
	logic                   q_push, q_full, q_pop, q_valid;
	pec_job_t               push_job, head_job;
	pec_hold_t              bk_status, hold;

	// Configuration registers; the level count is clamped once here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q  <= RST_PAM_ORDER;
			lev_q    <= {RST_LEVEL_3, RST_LEVEL_2, RST_LEVEL_1, RST_LEVEL_0};
			period_q <= RST_PERIOD;
			half_q   <= RST_HALF_UI;
			trig_q   <= RST_TRIGGER;
		end else if (cfg_we) begin
			case (pec_cfg_idx_t'(cfg_index))
				CFG_PAM_ORDER:     order_q  <= cfg_data[2:0];
				CFG_LEVEL_ZERO:    lev_q[0] <= cfg_data[LEV_W-1:0];
				CFG_LEVEL_ONE:     lev_q[1] <= cfg_data[LEV_W-1:0];
				CFG_LEVEL_TWO:     lev_q[2] <= cfg_data[LEV_W-1:0];
				CFG_LEVEL_THREE:   lev_q[3] <= cfg_data[LEV_W-1:0];
				CFG_SAMPLE_PERIOD: period_q <= cfg_data;
				CFG_HALF_UI:       half_q   <= cfg_data;
				CFG_TRIGGER_PHASE: trig_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (order_q < 3'd2) begin
			cfg.n = 3'd2;
		end else if (order_q > 3'(TOP_ORD)) begin
			cfg.n = 3'(TOP_ORD);
		end else begin
			cfg.n = order_q;
		end
		cfg.lev     = lev_q;
		cfg.period  = period_q;
		cfg.half_ui = half_q;
		cfg.trigger = trig_q;
	end

	// The oldest job still reading history: the one in the back end, or else
	// the one at the head of the queue.
	always_comb begin
		if (bk_status.valid) begin
			hold = bk_status;
		end else begin
			hold.valid = q_valid;
			hold.wp    = head_job.wp;
		end
	end

	pec_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(2 * HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pec_front #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.INDEX_BITS   (INDEX_BITS),
		.DW           (DW),
		.AW           (AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.hold     (hold),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.q_push   (q_push),
		.q_job    (push_job),
		.q_full   (q_full)
	);

	pec_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (head_job)
	);

	pec_back #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.INDEX_BITS   (INDEX_BITS),
		.AW           (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_job    (head_job),
		.q_pop    (q_pop),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.status   (bk_status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// The front end never pushes into a full queue.
	`PEC_ASSERT_IMP(a_push_room, clk, arst_n, q_push, !q_full, "job pushed into full queue")
	// The back end only takes a job that is there.
	`PEC_ASSERT_IMP(a_pop_valid, clk, arst_n, q_pop, q_valid, "job taken from empty queue")
	// A job taken from the queue keeps the back end busy, so its history is held.
	`PEC_ASSERT_NXT(a_pop_busy, clk, arst_n, q_pop, bk_status.valid, "back end idle after pop")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import pec_pkg::*;

	// One input word: an ADC code and the flag that opens a new capture record.
	typedef struct {
		logic [15:0] code;
		bit          rec_start;
	} sample_word_t;

	// One edge word as the block should present it.
	typedef struct {
		bit        replaces;
		bit [62:0] time_fs;
		bit        level;
	} edge_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	pam_edge_clock_recovery_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Words waiting to be sent, and edges the block still owes us.
	sample_word_t pending_words[$];
	edge_word_t   edges_due[$];
	int           errors;
	bit           quiet_tx;
	bit           quiet_rx;

	// Shadow copy of the configuration registers.
	int unsigned    order_reg;
	longint         lvl[4];
	bit [31:0]      period_fs;
	bit [31:0]      half_ui;
	bit [31:0]      phase_fs;

	// Shadow copy of the block's edge state.
	longint         hist[64];
	bit [31:0]      samp_idx;
	bit [31:0]      xing_idx[2];
	bit             xing_rise[2];
	int unsigned    xing_cnt;
	bit             toggle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A generous ceiling on the whole run; a healthy run finishes far earlier.
	initial begin
		#20ms;
		$display("FAIL pam_edge_clock_recovery_top");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Works out what one accepted sample word produces, following the crossing
	// detection, merge window, history search and interpolation of the block.
	function automatic void track_edge(sample_word_t w);
		int unsigned n, j, lb;
		bit [31:0]   k, id, diff, base;
		longint      p2, c2, t2, a2, b2;
		longint unsigned span, dt, num, den, frac, tl;
		int          sym_end, sym_start;
		bit          rise, merging;
		int unsigned old_cnt;
		bit [31:0]   old_idx[2];
		bit          old_rise[2];
		edge_word_t  e;

		n = order_reg < 2 ? 2 : (order_reg > 4 ? 4 : order_reg);
		sym_end = -1;
		rise = 1'b0;
		merging = 1'b0;
		if (w.rec_start) begin
			samp_idx = 0;
			xing_cnt = 0;
			xing_rise[0] = 1'b0;
			xing_rise[1] = 1'b0;
			toggle = 1'b1;
		end
		for (int i = 63; i > 0; i--)
			hist[i] = hist[i - 1];
		hist[0] = longint'($signed(w.code));
		k = samp_idx;
		samp_idx = k + 1;
		if (k < 2)
			return;
		id = k - 1;

		// The pair just completed sits at history positions two and one.
		p2 = 2 * hist[2];
		c2 = 2 * hist[1];
		for (j = 0; j + 1 < n; j++) begin
			t2 = lvl[j] + lvl[j + 1];
			if (p2 <= t2 && c2 > t2) begin
				rise = 1'b1;
				sym_end = j + 1;
				break;
			end
			if (p2 >= t2 && c2 < t2) begin
				rise = 1'b0;
				sym_end = j;
				break;
			end
		end
		if (sym_end < 0)
			return;

		old_cnt = xing_cnt;
		old_idx = xing_idx;
		old_rise = xing_rise;
		xing_idx[1] = xing_idx[0];
		xing_rise[1] = xing_rise[0];
		xing_idx[0] = id;
		xing_rise[0] = rise;
		if (xing_cnt < 3)
			xing_cnt++;
		// A crossing on the very first pair is only remembered.
		if (id == 1)
			return;

		sym_start = rise ? sym_end - 1 : sym_end + 1;
		span = 1;
		for (lb = 1; lb + 1 < n && lb <= 2; lb++) begin
			if (old_cnt <= lb)
				break;
			diff = id - old_idx[lb - 1];
			dt = longint'(diff) * longint'(period_fs);
			if (old_rise[lb - 1] != rise || dt >= longint'(half_ui))
				break;
			merging = 1'b1;
			span = longint'(diff) + 1;
			sym_start = rise ? sym_end - int'(lb + 1) : sym_end + int'(lb + 1);
		end
		if (sym_start < 0)
			sym_start = 0;
		if (sym_start > int'(n) - 1)
			sym_start = n - 1;
		if (span > 61)
			span = 61;
		if (span > longint'(id) - 1)
			span = longint'(id) - 1;

		// Oldest pair first; the first pair to straddle the target wins.
		t2 = lvl[sym_start] + lvl[sym_end];
		tl = 0;
		forever begin
			a2 = 2 * hist[2 + span];
			b2 = 2 * hist[1 + span];
			if ((a2 <= t2 && b2 > t2) || (a2 >= t2 && b2 < t2)) begin
				num = a2 <= t2 ? t2 - a2 : a2 - t2;
				den = b2 > a2 ? b2 - a2 : a2 - b2;
				frac = den != 0 ? (num << 16) / den : 0;
				if (frac > 64'hFFFF)
					frac = 64'hFFFF;
				base = id - 32'(span) - 1;
				tl = longint'(base) * longint'(period_fs)
					+ ((frac * longint'(period_fs)) >> 16);
				break;
			end
			if (span == 0)
				break;
			span--;
		end
		tl += longint'($signed(phase_fs));

		e.time_fs = tl[62:0];
		e.replaces = merging;
		if (!merging) begin
			e.level = toggle;
			toggle = ~toggle;
		end else begin
			e.level = ~toggle;
		end
		edges_due.insert(edges_due.size(), e);
	endfunction

	// Driver: presents queued words, holding each until it is taken, with gaps.
	int unsigned  tx_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				track_edge('{code: s_tdata, rec_start: s_tuser});
			if (!(s_tvalid && !s_tready)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					sample_word_t w;
					w = pending_words.pop_front();
					s_tdata <= w.code;
					s_tuser <= w.rec_start;
					s_tvalid <= 1'b1;
					tx_gap = quiet_tx ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls the output at random and checks each edge word taken.
	int unsigned rx_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (edges_due.size() == 0) begin
					$display("%0t: unexpected edge word kind=%0b data=%h", $time,
						m_tuser, m_tdata);
					errors++;
				end else begin
					edge_word_t e;
					e = edges_due.pop_front();
					if (m_tuser !== e.replaces || m_tdata[62:0] !== e.time_fs
						|| m_tdata[63] !== e.level) begin
						$display("%0t: edge mismatch expected kind=%0b time=%0d value=%0b",
							$time, e.replaces, e.time_fs, e.level);
						$display("%0t:               actual kind=%0b time=%0d value=%0b",
							$time, m_tuser, m_tdata[62:0], m_tdata[63]);
						errors++;
					end
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_gap = quiet_rx ? 0 : ($urandom_range(0, 2) == 0 ? pick_gap() : 0);
			end
		end
	end

	task automatic write_reg(pec_cfg_idx_t which, bit [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		case (which)
			CFG_PAM_ORDER:     order_reg = value[2:0];
			CFG_LEVEL_ZERO:    lvl[0] = longint'($signed(value[15:0]));
			CFG_LEVEL_ONE:     lvl[1] = longint'($signed(value[15:0]));
			CFG_LEVEL_TWO:     lvl[2] = longint'($signed(value[15:0]));
			CFG_LEVEL_THREE:   lvl[3] = longint'($signed(value[15:0]));
			CFG_SAMPLE_PERIOD: period_fs = value;
			CFG_HALF_UI:       half_ui = value;
			default:           phase_fs = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Lets the sender run dry and every owed edge arrive, then allows for a
	// crossing that is still being worked on without producing a word.
	task automatic drain();
		wait (pending_words.size() == 0);
		do @(posedge clk); while (s_tvalid || edges_due.size() != 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic push_word(int code, bit rs);
		sample_word_t w;
		if (code > 32767)
			code = 32767;
		if (code < -32768)
			code = -32768;
		w.code = 16'(code);
		w.rec_start = rs;
		pending_words.insert(pending_words.size(), w);
	endtask

	// A well-formed capture: random symbols held for a few samples each, joined
	// by short ramps and overlaid with a little noise.
	task automatic push_record(int n_sym, int hold, int ramp, int noise);
		int unsigned n, sym, nxt;
		int          a, b;
		bit          first;
		n = order_reg < 2 ? 2 : (order_reg > 4 ? 4 : order_reg);
		sym = $urandom_range(0, n - 1);
		first = 1'b1;
		for (int i = 0; i < n_sym; i++) begin
			nxt = $urandom_range(0, n - 1);
			a = int'(lvl[sym]);
			b = int'(lvl[nxt]);
			for (int h = 0; h < hold; h++) begin
				push_word(a + $urandom_range(0, 2 * noise) - noise, first);
				first = 1'b0;
			end
			for (int r = 1; r < ramp; r++)
				push_word(a + (b - a) * r / ramp + $urandom_range(0, 2 * noise) - noise, 1'b0);
			sym = nxt;
		end
	endtask

	// Random records at the current setting until the phase has its share.
	task automatic random_phase(int words);
		int target;
		target = words;
		while (target > 0) begin
			int before_len;
			before_len = pending_words.size();
			quiet_tx = $urandom_range(0, 4) == 0;
			quiet_rx = $urandom_range(0, 4) == 0;
			if ($urandom_range(0, 5) == 0) begin
				// Noise: full-range codes with the odd stray record start.
				repeat ($urandom_range(5, 25))
					push_word($signed(16'($urandom)), $urandom_range(0, 29) == 0);
			end else if ($urandom_range(0, 7) == 0) begin
				// A broken record: cut short before its first symbol settles.
				push_record(1, $urandom_range(1, 2), $urandom_range(1, 3), 50);
			end else begin
				push_record($urandom_range(4, 16), $urandom_range(1, 6),
					$urandom_range(1, 4), $urandom_range(0, 300));
			end
			target -= pending_words.size() - before_len;
			wait (pending_words.size() < 8);
		end
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		drain();
	endtask

	initial begin
		errors = 0;
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PAM_ORDER;
		cfg_data = '0;
		order_reg = 3;
		lvl[0] = -16384;
		lvl[1] = 0;
		lvl[2] = 16384;
		lvl[3] = 32767;
		period_fs = 100000;
		half_ui = 400000;
		phase_fs = 0;
		foreach (hist[i])
			hist[i] = 0;
		samp_idx = 0;
		xing_idx[0] = 0;
		xing_idx[1] = 0;
		xing_rise[0] = 1'b0;
		xing_rise[1] = 1'b0;
		xing_cnt = 0;
		toggle = 1'b1;

		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset settings. A crossing on the first pair
		// is remembered but not reported; full-scale codes follow.
		push_word(-20000, 1'b1);
		push_word(20000, 1'b0);
		push_word(-32768, 1'b0);
		push_word(32767, 1'b0);
		push_word(32767, 1'b0);
		push_word(-32768, 1'b0);
		push_word(-1, 1'b0);
		push_word(0, 1'b0);
		push_word(1, 1'b0);
		// A new record whose first pair is already a crossing, then a
		// steep three-level climb that merges into one replaced edge.
		push_word(30000, 1'b1);
		push_word(-30000, 1'b0);
		push_word(-20000, 1'b0);
		push_word(-4000, 1'b0);
		push_word(12000, 1'b0);
		push_word(24000, 1'b0);
		push_word(24000, 1'b0);
		push_word(-24000, 1'b0);
		push_word(-24000, 1'b0);
		drain();

		// PAM4 with an offset trigger phase.
		write_reg(CFG_PAM_ORDER, 32'd4);
		write_reg(CFG_LEVEL_ZERO, 32'(-24000));
		write_reg(CFG_LEVEL_ONE, 32'(-8000));
		write_reg(CFG_LEVEL_TWO, 32'd8000);
		write_reg(CFG_LEVEL_THREE, 32'd24000);
		write_reg(CFG_TRIGGER_PHASE, 32'd12345);
		// A full-swing jump: the outer crossings merge into the middle one.
		push_word(-24000, 1'b1);
		push_word(-24000, 1'b0);
		push_word(-10000, 1'b0);
		push_word(10000, 1'b0);
		push_word(24000, 1'b0);
		push_word(24000, 1'b0);
		push_word(-24000, 1'b0);
		random_phase(260);

		// PAM2, full-scale levels, shortest period, widest window, most
		// negative phase.
		write_reg(CFG_PAM_ORDER, 32'd2);
		write_reg(CFG_LEVEL_ZERO, 32'(-32768));
		write_reg(CFG_LEVEL_ONE, 32'd32767);
		write_reg(CFG_SAMPLE_PERIOD, 32'd1);
		write_reg(CFG_HALF_UI, 32'hFFFF_FFFF);
		write_reg(CFG_TRIGGER_PHASE, 32'h8000_0000);
		random_phase(260);

		// PAM4, longest period, narrowest window, most positive phase.
		write_reg(CFG_PAM_ORDER, 32'd4);
		write_reg(CFG_LEVEL_ZERO, 32'(-32768));
		write_reg(CFG_LEVEL_ONE, 32'(-1));
		write_reg(CFG_LEVEL_TWO, 32'd0);
		write_reg(CFG_LEVEL_THREE, 32'd32767);
		write_reg(CFG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
		write_reg(CFG_HALF_UI, 32'd1);
		write_reg(CFG_TRIGGER_PHASE, 32'h7FFF_FFFF);
		random_phase(260);

		// PAM3 with random levels, period, window and phase.
		write_reg(CFG_PAM_ORDER, 32'd3);
		write_reg(CFG_LEVEL_ZERO, 32'($urandom_range(0, 20000)) - 32'd30000);
		write_reg(CFG_LEVEL_ONE, 32'($urandom_range(0, 8000)) - 32'd4000);
		write_reg(CFG_LEVEL_TWO, 32'($urandom_range(10000, 30000)));
		write_reg(CFG_SAMPLE_PERIOD, 32'($urandom_range(1, 200000)));
		write_reg(CFG_HALF_UI, 32'($urandom_range(1, 1000000)));
		write_reg(CFG_TRIGGER_PHASE, $urandom);
		random_phase(300);

		// PAM4 where merging is common.
		write_reg(CFG_PAM_ORDER, 32'd4);
		write_reg(CFG_LEVEL_ZERO, 32'(-27000));
		write_reg(CFG_LEVEL_ONE, 32'(-9000));
		write_reg(CFG_LEVEL_TWO, 32'd9000);
		write_reg(CFG_LEVEL_THREE, 32'd27000);
		write_reg(CFG_SAMPLE_PERIOD, 32'd50000);
		write_reg(CFG_HALF_UI, 32'd300000);
		write_reg(CFG_TRIGGER_PHASE, 32'(-777));
		random_phase(320);

		// Back to the reset values to close.
		write_reg(CFG_PAM_ORDER, 32'(RST_PAM_ORDER));
		write_reg(CFG_LEVEL_ZERO, 32'($signed(RST_LEVEL_0)));
		write_reg(CFG_LEVEL_ONE, 32'($signed(RST_LEVEL_1)));
		write_reg(CFG_LEVEL_TWO, 32'($signed(RST_LEVEL_2)));
		write_reg(CFG_LEVEL_THREE, 32'($signed(RST_LEVEL_3)));
		write_reg(CFG_SAMPLE_PERIOD, RST_PERIOD);
		write_reg(CFG_HALF_UI, RST_HALF_UI);
		write_reg(CFG_TRIGGER_PHASE, RST_TRIGGER);
		random_phase(230);

		if (errors == 0 && edges_due.size() == 0) begin
			$display("PASS pam_edge_clock_recovery_top");
		end else begin
			$display("FAIL pam_edge_clock_recovery_top");
		end
		$finish;
	end

endmodule
